@@ src/outward_spiral_address_generator_macros.svh @@
// Assertion macros shared by the spiral address generator modules.
`ifndef OUTWARD_SPIRAL_ADDRESS_GENERATOR_MACROS_SVH
`define OUTWARD_SPIRAL_ADDRESS_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OSAG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spiral generator check failed");

// Next-cycle implication, checked outside reset.
`define OSAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spiral generator check failed");

`endif

@@ src/osag_pkg.sv @@
// Types, register indexes and start-point tables of the spiral address generator.
package osag_pkg;

    localparam int COORD_W = 7;
    localparam int ORDER_W = 14;
    localparam int CFG_W   = 7;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_START_DIR  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_TURN_SENSE = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
    localparam logic       TURN_CW   = 1'b0;
    localparam logic       TURN_CCW  = 1'b1;

    // Tables indexed by {start_direction, turn_sense}.
    localparam logic [7:0] EVEN_ROW_BACK = 8'b0110_1100;
    localparam logic [7:0] EVEN_COL_BACK = 8'b1100_1001;
    localparam logic [7:0] INIT_HPHASE   = 8'b0011_0110;
    localparam logic [7:0] INIT_VPHASE   = 8'b0110_1100;

    typedef struct packed {
        logic [CFG_W-1:0] grid_size;
        logic [1:0]       start_dir;
        logic             turn_sense;
    } t_cfg;

    typedef struct packed {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [12:0] order;
        logic        valid;
        logic        last;
    } t_cell;

endpackage

@@ src/outward_spiral_address_generator.sv @@
// Top level of the outward spiral address generator.
// Each accepted item yields exactly one result item: restart=1 starts a new walk at the centre
// and returns its first cell, restart=0 returns the next cell of the spiral, and once the walk
// has given cell number N*N every further item returns cell_valid=0. An item is turned into its
// result combinationally by the walk logic and is registered in the output buffer, so one item
// can be accepted every cycle while the buffer has room. The output side is two entries deep, so
// the input keeps taking items while one result waits; it stalls only when both entries are full.
// The grid size, start direction and turn sense are sampled at a restart; N*N is formed then
// by one 7x7 multiplier and kept for the last-cell check. New configuration applies at a restart.
module outward_spiral_address_generator #(
    parameter int MAX_GRID = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_cell_row,
    output logic [5:0]  o_cell_col,
    output logic [12:0] o_order_number,
    output logic        o_cell_valid,
    output logic        o_last_cell
);

    osag_pkg::t_cfg  r_cfg;
    osag_pkg::t_cell s_cell, s_out_cell;
    logic            s_accept, s_full;

    assign o_in_stall = s_full;
    assign s_accept   = i_in_valid && !s_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size  <= 7'd1;
            r_cfg.start_dir  <= osag_pkg::DIR_UP;
            r_cfg.turn_sense <= osag_pkg::TURN_CW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                osag_pkg::REG_GRID_SIZE:  r_cfg.grid_size  <= i_cfg_wdata;
                osag_pkg::REG_START_DIR:  r_cfg.start_dir  <= i_cfg_wdata[1:0];
                osag_pkg::REG_TURN_SENSE: r_cfg.turn_sense <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    osag_walk #(
        .MAX_GRID (MAX_GRID)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_step    (s_accept),
        .i_restart (i_restart),
        .o_cell    (s_cell)
    );

    osag_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_accept),
        .i_cell      (s_cell),
        .o_full      (s_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cell      (s_out_cell)
    );

    assign o_cell_row     = s_out_cell.row;
    assign o_cell_col     = s_out_cell.col;
    assign o_order_number = s_out_cell.order;
    assign o_cell_valid   = s_out_cell.valid;
    assign o_last_cell    = s_out_cell.last;

endmodule

@@ src/osag_walk.sv @@
// Spiral walk state and the combinational step that yields one cell per item.
`include "outward_spiral_address_generator_macros.svh"

module osag_walk #(
    parameter int MAX_GRID = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  osag_pkg::t_cfg i_cfg,
    input  logic           i_step,
    input  logic           i_restart,
    output osag_pkg::t_cell o_cell
);

    localparam int CW = osag_pkg::COORD_W;
    localparam int OW = osag_pkg::ORDER_W;

    logic [CW-1:0] r_row, r_col, r_leg, r_step_cnt;
    logic [OW-1:0] r_order, r_total;
    logic          r_second, r_hph, r_vph, r_hfirst, r_done;

    logic [CW-1:0] n_row, n_col, n_leg, n_step_cnt;
    logic [OW-1:0] n_order, n_total;
    logic          n_second, n_hph, n_vph, n_hfirst, n_done;

    logic [CW-1:0] s_n, s_half, s_row0, s_col0;
    logic [2:0]    s_sel;
    logic          s_clamp;

    logic [CW-1:0] e_row, e_col, e_leg, e_step_cnt, e_step_inc;
    logic [OW-1:0] e_order;
    logic          e_second, e_hph, e_vph, e_hfirst, e_done, e_last, e_horiz;

    // Start point and grid size as seen at a restart.
    always_comb begin
        s_clamp = int'(i_cfg.grid_size) > MAX_GRID;
        if (i_cfg.grid_size == '0) begin
            s_n = CW'(1);
        end else if (s_clamp) begin
            s_n = CW'(MAX_GRID);
        end else begin
            s_n = i_cfg.grid_size;
        end
        s_sel  = {i_cfg.start_dir, i_cfg.turn_sense};
        s_half = s_n >> 1;
        s_row0 = s_n[0] ? s_half : s_half - CW'(osag_pkg::EVEN_ROW_BACK[s_sel]);
        s_col0 = s_n[0] ? s_half : s_half - CW'(osag_pkg::EVEN_COL_BACK[s_sel]);
    end

    // A restart replaces the running state before the cell is produced.
    always_comb begin
        if (i_restart) begin
            e_row      = s_row0;
            e_col      = s_col0;
            e_order    = OW'(1);
            e_leg      = CW'(1);
            e_step_cnt = '0;
            e_second   = 1'b0;
            e_hph      = osag_pkg::INIT_HPHASE[s_sel];
            e_vph      = osag_pkg::INIT_VPHASE[s_sel];
            e_hfirst   = i_cfg.start_dir[1];
            e_done     = 1'b0;
            e_last     = (s_n == CW'(1));
            n_total    = OW'(s_n) * OW'(s_n);
        end else begin
            e_row      = r_row;
            e_col      = r_col;
            e_order    = r_order;
            e_leg      = r_leg;
            e_step_cnt = r_step_cnt;
            e_second   = r_second;
            e_hph      = r_hph;
            e_vph      = r_vph;
            e_hfirst   = r_hfirst;
            e_done     = r_done;
            e_last     = (r_order >= r_total);
            n_total    = r_total;
        end
    end

    always_comb begin
        o_cell.valid = !e_done;
        o_cell.row   = e_done ? 6'd0  : e_row[5:0];
        o_cell.col   = e_done ? 6'd0  : e_col[5:0];
        o_cell.order = e_done ? 13'd0 : e_order[12:0];
        o_cell.last  = !e_done && e_last;

        e_horiz    = e_hfirst ^ e_second;
        e_step_inc = e_step_cnt + CW'(1);

        n_row      = e_row;
        n_col      = e_col;
        n_order    = e_order;
        n_leg      = e_leg;
        n_step_cnt = e_step_cnt;
        n_second   = e_second;
        n_hph      = e_hph;
        n_vph      = e_vph;
        n_hfirst   = e_hfirst;
        n_done     = e_done;

        if (!e_done) begin
            if (e_last) begin
                n_done = 1'b1;
            end else begin
                n_order = e_order + OW'(1);
                if (e_horiz) begin
                    n_col = e_hph ? e_col - CW'(1) : e_col + CW'(1);
                end else begin
                    n_row = e_vph ? e_row + CW'(1) : e_row - CW'(1);
                end
                n_step_cnt = e_step_inc;
                // End of a leg: flip the sign of the axis just walked and swap axes.
                if (e_step_inc >= e_leg) begin
                    n_step_cnt = '0;
                    if (e_horiz) begin
                        n_hph = !e_hph;
                    end else begin
                        n_vph = !e_vph;
                    end
                    if (e_second) begin
                        n_leg = e_leg + CW'(1);
                    end
                    n_second = !e_second;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_order    <= OW'(1);
            r_total    <= OW'(1);
            r_leg      <= CW'(1);
            r_step_cnt <= '0;
            r_second   <= 1'b0;
            r_hph      <= 1'b0;
            r_vph      <= 1'b0;
            r_hfirst   <= 1'b0;
            r_done     <= 1'b1;
        end else if (i_step) begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_order    <= n_order;
            r_total    <= n_total;
            r_leg      <= n_leg;
            r_step_cnt <= n_step_cnt;
            r_second   <= n_second;
            r_hph      <= n_hph;
            r_vph      <= n_vph;
            r_hfirst   <= n_hfirst;
            r_done     <= n_done;
        end
    end

    `OSAG_ASSERT_NOW(a_order_in_range, !r_done, (r_order <= r_total) && (r_order != '0))
    `OSAG_ASSERT_NEXT(a_done_holds, r_done && !(i_step && i_restart), r_done)

endmodule

@@ src/osag_obuf.sv @@
// Two-entry output buffer: result register plus skid entry.
`include "outward_spiral_address_generator_macros.svh"

module osag_obuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  osag_pkg::t_cell i_cell,
    output logic            o_full,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output osag_pkg::t_cell o_cell
);

    logic            r_out_valid, r_skid_valid;
    osag_pkg::t_cell r_out, r_skid;
    logic            s_take;

    assign s_take      = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_cell      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (s_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || s_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (s_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (s_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || s_take) begin
                r_out <= i_cell;
            end else begin
                r_skid <= i_cell;
            end
        end
    end

    `OSAG_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `OSAG_ASSERT_NEXT(a_no_push_when_full, r_skid_valid && i_out_stall, r_skid_valid && r_out_valid)

endmodule

@@ sim/spiral_cell_checker.sv @@
// Checker that predicts the spiral walk and compares every result item of the generator.
module spiral_cell_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_restart,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic [12:0] i_order_number,
    input  logic        i_cell_valid,
    input  logic        i_last_cell,
    output int          o_cells_pending,
    output int          o_fail_count
);

    localparam int MAX_SIDE = 64;

    // Start-point tables, bit {start_direction, turn_sense}.
    localparam logic [7:0] ROW_BACK_EVEN = 8'b0110_1100;
    localparam logic [7:0] COL_BACK_EVEN = 8'b1100_1001;
    localparam logic [7:0] START_LEFT    = 8'b0011_0110;
    localparam logic [7:0] START_DOWN    = 8'b0110_1100;

    logic [6:0] grid_reg;
    logic [1:0] dir_reg;
    logic       turn_reg;

    logic [6:0] row_pos;
    logic [6:0] col_pos;
    int         order_next;
    int         leg_len;
    int         leg_step;
    logic       on_second_leg;
    logic       going_left;
    logic       going_down;
    logic       walk_idle;
    int         walk_side;
    logic       horiz_leg_first;

    osag_pkg::t_cell expected_cells[$];
    int              fails;

    initial begin
        o_cells_pending = 0;
        o_fail_count    = 0;
        fails           = 0;
    end

    function automatic osag_pkg::t_cell next_spiral_cell(input logic restart_bit);
        osag_pkg::t_cell pred;
        logic [2:0]      sel;
        int              half;
        logic            horiz_now;
        pred = '0;
        if (restart_bit) begin
            sel = {dir_reg, turn_reg};
            if (grid_reg == 7'd0) walk_side = 1;
            else if (int'(grid_reg) > MAX_SIDE) walk_side = MAX_SIDE;
            else walk_side = int'(grid_reg);
            half = walk_side / 2;
            if (walk_side % 2 == 0) begin
                row_pos = 7'(half - int'(ROW_BACK_EVEN[sel]));
                col_pos = 7'(half - int'(COL_BACK_EVEN[sel]));
            end else begin
                row_pos = 7'(half);
                col_pos = 7'(half);
            end
            order_next      = 1;
            leg_len         = 1;
            leg_step        = 0;
            on_second_leg   = 1'b0;
            going_left      = START_LEFT[sel];
            going_down      = START_DOWN[sel];
            horiz_leg_first = (dir_reg == osag_pkg::DIR_LEFT) || (dir_reg == osag_pkg::DIR_RIGHT);
            walk_idle       = 1'b0;
        end
        if (walk_idle) return pred;

        pred.row   = row_pos[5:0];
        pred.col   = col_pos[5:0];
        pred.order = 13'(order_next);
        pred.valid = 1'b1;
        pred.last  = (order_next >= walk_side * walk_side);
        if (pred.last) begin
            walk_idle = 1'b1;
            return pred;
        end

        order_next++;
        horiz_now = horiz_leg_first ^ on_second_leg;
        if (horiz_now) col_pos = going_left ? col_pos - 7'd1 : col_pos + 7'd1;
        else row_pos = going_down ? row_pos + 7'd1 : row_pos - 7'd1;

        leg_step++;
        if (leg_step >= leg_len) begin
            leg_step = 0;
            if (horiz_now) going_left = ~going_left;
            else going_down = ~going_down;
            if (on_second_leg) leg_len++;
            on_second_leg = ~on_second_leg;
        end
        return pred;
    endfunction

    function automatic int field_mismatch(input string name, input logic [12:0] want,
                                          input logic [12:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        osag_pkg::t_cell want;
        int              bad;
        if (!i_rst_n) begin
            grid_reg        = 7'd1;
            dir_reg         = osag_pkg::DIR_UP;
            turn_reg        = osag_pkg::TURN_CW;
            row_pos         = '0;
            col_pos         = '0;
            order_next      = 1;
            leg_len         = 1;
            leg_step        = 0;
            on_second_leg   = 1'b0;
            going_left      = 1'b0;
            going_down      = 1'b0;
            walk_idle       = 1'b1;
            walk_side       = 1;
            horiz_leg_first = 1'b0;
            expected_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    osag_pkg::REG_GRID_SIZE:  grid_reg = i_cfg_wdata;
                    osag_pkg::REG_START_DIR:  dir_reg  = i_cfg_wdata[1:0];
                    osag_pkg::REG_TURN_SENSE: turn_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_cells.push_back(next_spiral_cell(i_restart));

            if (i_out_valid && !i_out_stall) begin
                if (expected_cells.size() == 0) begin
                    $error("result item arrived with no item waiting for it");
                    fails++;
                end else begin
                    want = expected_cells.pop_front();
                    bad = field_mismatch("cell_row", 13'(want.row), 13'(i_cell_row))
                        + field_mismatch("cell_col", 13'(want.col), 13'(i_cell_col))
                        + field_mismatch("order_number", want.order, i_order_number)
                        + field_mismatch("cell_valid", 13'(want.valid), 13'(i_cell_valid))
                        + field_mismatch("last_cell", 13'(want.last), 13'(i_last_cell));
                    fails += bad;
                end
            end
        end
        o_cells_pending <= expected_cells.size();
        o_fail_count    <= fails;
    end

endmodule

@@ sim/outward_spiral_address_generator_test.sv @@
// Testbench top for the spiral address generator: stimulus, pacing and the final verdict.
module outward_spiral_address_generator_test;

    localparam int               RANDOM_ITEMS = 800;
    localparam int               CYCLE_LIMIT  = 40000;
    localparam logic [1:0]       REG_SPARE    = 2'd3;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [1:0]  i_cfg_index  = '0;
    logic [6:0]  i_cfg_wdata  = '0;
    logic        i_in_valid   = 1'b0;
    logic        i_restart    = 1'b0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [5:0]  o_cell_row;
    logic [5:0]  o_cell_col;
    logic [12:0] o_order_number;
    logic        o_cell_valid;
    logic        o_last_cell;

    int          cells_pending;
    int          fail_count;
    int          cycle_count   = 0;
    int          send_gap_pct  = 31;
    int          out_stall_pct = 31;
    logic [6:0]  cfg_grid      = 7'd1;

    outward_spiral_address_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cell_row     (o_cell_row),
        .o_cell_col     (o_cell_col),
        .o_order_number (o_order_number),
        .o_cell_valid   (o_cell_valid),
        .o_last_cell    (o_last_cell)
    );

    spiral_cell_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_restart       (i_restart),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_cell_row      (o_cell_row),
        .i_cell_col      (o_cell_col),
        .i_order_number  (o_order_number),
        .i_cell_valid    (o_cell_valid),
        .i_last_cell     (o_last_cell),
        .o_cells_pending (cells_pending),
        .o_fail_count    (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Holds valid until the item is taken; the gap is chosen only after acceptance.
    task automatic push_step(input logic restart_bit);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart_bit;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (cells_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_walk(input int steps, input logic lead_restart, input int noise_pct);
        int k;
        if (lead_restart) push_step(1'b1);
        for (k = 0; k < steps; k++) push_step($urandom_range(99) < noise_pct);
        i_in_valid <= 1'b0;
        settle();
    endtask

    // Bit 0..3 of which selects grid size, start direction, turn sense and the spare index.
    task automatic program_config(input logic [6:0] grid_val, input logic [1:0] dir_val,
                                  input logic turn_val, input logic [3:0] which);
        if (which != 4'd0) begin
            i_cfg_we <= 1'b1;
            if (which[0]) begin
                i_cfg_index <= osag_pkg::REG_GRID_SIZE;
                i_cfg_wdata <= grid_val;
                cfg_grid = grid_val;
                @(posedge i_clk);
            end
            if (which[1]) begin
                i_cfg_index <= osag_pkg::REG_START_DIR;
                i_cfg_wdata <= {5'($urandom_range(31)), dir_val};
                @(posedge i_clk);
            end
            if (which[2]) begin
                i_cfg_index <= osag_pkg::REG_TURN_SENSE;
                i_cfg_wdata <= {6'($urandom_range(63)), turn_val};
                @(posedge i_clk);
            end
            if (which[3]) begin
                i_cfg_index <= REG_SPARE;
                i_cfg_wdata <= 7'($urandom_range(127));
                @(posedge i_clk);
            end
            i_cfg_we <= 1'b0;
        end
    endtask

    initial begin
        int pick;
        int grid_pick;
        int side;
        int cells;
        int steps;
        int random_items;
        random_items = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // A step before any restart must report no cell; then the one-cell grid.
        run_walk(1, 1'b0, 0);
        run_walk(1, 1'b1, 0);
        program_config(7'd0, osag_pkg::DIR_DOWN, osag_pkg::TURN_CCW, 4'b1111);
        run_walk(1, 1'b1, 0);
        program_config(7'd3, osag_pkg::DIR_RIGHT, osag_pkg::TURN_CW, 4'b0111);
        run_walk(4, 1'b1, 0);
        // New settings must not disturb the walk already under way.
        program_config(7'd2, osag_pkg::DIR_UP, osag_pkg::TURN_CCW, 4'b0111);
        run_walk(5, 1'b0, 0);
        program_config(7'd2, osag_pkg::DIR_LEFT, osag_pkg::TURN_CCW, 4'b0111);
        push_step(1'b1);
        push_step(1'b0);
        run_walk(4, 1'b1, 0);

        // One full walk of a large grid with no idling on either side.
        send_gap_pct  = 0;
        out_stall_pct = 0;
        program_config(7'd32, 2'($urandom_range(3)), 1'($urandom_range(1)), 4'b0111);
        run_walk(1024, 1'b1, 0);
        send_gap_pct  = 31;
        out_stall_pct = 31;
        program_config(7'd127, 2'($urandom_range(3)), 1'($urandom_range(1)), 4'b0111);
        run_walk(200, 1'b1, 3);

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) grid_pick = $urandom_range(1, 8);
            else if (pick < 80) grid_pick = $urandom_range(9, 16);
            else if (pick < 90) grid_pick = $urandom_range(17, 63);
            else if (pick < 95) grid_pick = 0;
            else grid_pick = $urandom_range(64, 127);
            program_config(7'(grid_pick), 2'($urandom_range(3)), 1'($urandom_range(1)),
                           4'($urandom_range(1, 15)));
            if (cfg_grid == 7'd0) side = 1;
            else if (cfg_grid > 7'd64) side = 64;
            else side = int'(cfg_grid);
            cells = side * side;

            pick          = ($urandom_range(99) < 15) ? 0 : 31;
            send_gap_pct  = pick;
            out_stall_pct = pick;

            pick = $urandom_range(99);
            if (pick < 70 && cells <= 300) begin
                steps = cells - 1 + $urandom_range(0, 3);
                run_walk(steps, 1'b1, 0);
            end else if (pick < 88) begin
                steps = $urandom_range(0, (cells < 300) ? cells : 300);
                run_walk(steps, 1'b1, 3);
            end else begin
                steps = $urandom_range(1, 40);
                run_walk(steps, 1'b0, 3);
            end
            random_items += steps + 1;
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
